// ===== design/pvp_pkg.sv =====
`timescale 1ns / 1ps
package pvp_pkg;

    localparam int CordicStepsDef = 16;
    localparam int CordicStepsMax = 24;
    localparam int StepW = 5;
    localparam int Cw = 44;     // cordic x/y width
    localparam int Zw = 36;     // cordic angle width, q.30 radians

    localparam logic [2:0] REG_GAIN_KP   = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED = 3'd1;
    localparam logic [2:0] REG_ACCEL     = 3'd2;
    localparam logic [2:0] REG_MIN_SPEED = 3'd3;
    localparam logic [2:0] REG_STOP_TOL  = 3'd4;
    localparam logic [2:0] REG_TICK      = 3'd5;

    localparam logic [1:0] KIND_GOAL  = 2'd0;
    localparam logic [1:0] KIND_ABORT = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic start;
        logic vec;      // 1 vectoring, 0 rotation
    } t_cor_ctl;

    function automatic logic [29:0] pvp_atan(input logic [StepW-1:0] i);
        logic [29:0] a;
        case (i)
            5'd0:  a = 30'd843314856;
            5'd1:  a = 30'd497837829;
            5'd2:  a = 30'd263043836;
            5'd3:  a = 30'd133525158;
            5'd4:  a = 30'd67021686;
            5'd5:  a = 30'd33543515;
            5'd6:  a = 30'd16775850;
            5'd7:  a = 30'd8388437;
            5'd8:  a = 30'd4194282;
            5'd9:  a = 30'd2097149;
            5'd10: a = 30'd1048575;
            5'd11: a = 30'd524287;
            5'd12: a = 30'd262143;
            5'd13: a = 30'd131071;
            5'd14: a = 30'd65535;
            5'd15: a = 30'd32767;
            5'd16: a = 30'd16383;
            5'd17: a = 30'd8191;
            5'd18: a = 30'd4095;
            5'd19: a = 30'd2047;
            5'd20: a = 30'd1023;
            5'd21: a = 30'd511;
            5'd22: a = 30'd255;
            5'd23: a = 30'd127;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== design/pvp_cordic.sv =====
`timescale 1ns / 1ps
module pvp_cordic #(
    parameter int CORDIC_STEPS = pvp_pkg::CordicStepsDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pvp_pkg::t_cor_ctl               i_ctl,
    input  logic signed [pvp_pkg::Cw-1:0]   i_x,
    input  logic signed [pvp_pkg::Cw-1:0]   i_y,
    input  logic signed [pvp_pkg::Zw-1:0]   i_z,
    output logic                            o_done,
    output logic signed [pvp_pkg::Cw-1:0]   o_x,
    output logic signed [pvp_pkg::Cw-1:0]   o_y,
    output logic signed [pvp_pkg::Zw-1:0]   o_z
);
    import pvp_pkg::*;

    localparam int Steps = (CORDIC_STEPS > CordicStepsMax) ? CordicStepsMax : CORDIC_STEPS;
    localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);

    logic signed [Cw-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [Zw-1:0] r_z, n_z, ang;
    logic [StepW-1:0]     r_i;
    logic                 r_busy, r_vec, r_done, dir;

    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;
    assign ang = signed'({{(Zw-30){1'b0}}, pvp_atan(r_i)});
    // vectoring drives y to zero, rotation drives z to zero
    assign dir = r_vec ? (r_y > 0) : r_z[Zw-1];

    always_comb begin
        if (dir) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + ang;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_ctl.vec;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ===== design/point_to_point_velocity_profiler.sv =====
`timescale 1ns / 1ps
// point-to-point velocity profiler
// input channel: i_valid / o_stall with i_kind, i_pos_x, i_pos_y, i_heading.
// kind goal stores a target and starts moving, abort or a goal at (-1,-1) goes idle,
// tick carries the pose. goal, abort and unused kinds give no result.
// output channel: o_valid / i_stall with o_vel_x, o_vel_y, o_reached.
// config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index, i_cfg_data.
// a moving tick runs squares, a bit-pair square root, speed limiting on the shared
// multiplier, a vectoring cordic pass for the bearing and a rotation cordic pass
// for the velocity, then the output state; a new item is taken only once the
// sequencer is back in idle, after the result is in the output register.
// ticks while idle pass straight to the output state; goal items finish in the idle state.
// o_stall is high while an item is in work; the result is held in an output
// register, and the sequencer waits in its last state while i_stall holds it.
// reset restores the default registers, clears goal and speed, mode idle.
module point_to_point_velocity_profiler #(
    parameter int CORDIC_STEPS = pvp_pkg::CordicStepsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_vel_x,
    output logic signed [23:0] o_vel_y,
    output logic               o_reached,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [22:0]        i_cfg_data
);
    import pvp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQA  = 4'd1;
    localparam logic [3:0] S_SQB  = 4'd2;
    localparam logic [3:0] S_SQC  = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_KP   = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_LIM  = 4'd7;
    localparam logic [3:0] S_VEC  = 4'd8;
    localparam logic [3:0] S_INV  = 4'd9;
    localparam logic [3:0] S_ROT  = 4'd10;
    localparam logic [3:0] S_RWT  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    localparam logic [4:0]  SqrtLast = 5'd25;
    localparam logic signed [Zw-1:0] PiQ30    = 36'sd3373259426;
    localparam logic signed [Zw-1:0] HalfPi   = 36'sd1686629713;
    localparam logic signed [Zw-1:0] TwoPi    = 36'sd6746518852;
    localparam logic [29:0]          InvK     = 30'd652032874;
    localparam logic signed [23:0]   AbortPos = -24'sd65536;

    logic [15:0] r_kp, r_tick;
    logic [22:0] r_maxs, r_acc, r_mins, r_tol;

    logic signed [23:0] r_gx, r_gy, r_lvx, r_lvy, r_rx, r_ry;
    logic               r_moving, r_seen, r_rr;
    logic [22:0]        r_lspd, r_spd;
    logic [3:0]         r_state;

    logic signed [24:0] r_dx, r_dy;
    logic signed [15:0] r_hd;
    logic               r_zero;
    logic [24:0]        adx, ady;
    logic [25:0]        mul_a;
    logic [29:0]        mul_b;
    logic [55:0]        r_prod;
    logic [51:0]        r_n, r_b, sq_t;
    logic [51:0]        r_r;
    logic [4:0]         r_cnt;
    logic signed [Zw-1:0] r_theta, theta_raw, theta_w;

    logic [23:0] rise_sum;
    logic [22:0] spd_lim;

    t_cor_ctl             cor_ctl;
    logic signed [Cw-1:0] cor_x0, cor_y0, cor_xo, cor_yo, rnd_x, rnd_y, rot_x;
    logic signed [Zw-1:0] cor_z0, cor_zo;
    logic                 cor_done;

    logic                 r_ov, r_ovr;
    logic signed [23:0]   r_ovx, r_ovy;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);

    assign adx = r_dx[24] ? 25'(-r_dx) : 25'(r_dx);
    assign ady = r_dy[24] ? 25'(-r_dy) : 25'(r_dy);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQA: begin
                mul_a = {1'b0, adx};
                mul_b = {5'b0, adx};
            end
            S_SQB: begin
                mul_a = {1'b0, ady};
                mul_b = {5'b0, ady};
            end
            S_KP: begin
                mul_a = r_r[25:0];
                mul_b = {14'b0, r_kp};
            end
            S_ACC: begin
                mul_a = {3'b0, r_acc};
                mul_b = {14'b0, r_tick};
            end
            S_INV: begin
                mul_a = {3'b0, r_spd};
                mul_b = InvK;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sq_t = r_n - (r_r + r_b);

    // speed limit by acceleration, then floor
    always_comb begin
        rise_sum = {1'b0, r_lspd} + {1'b0, r_prod[38:16]};
        spd_lim  = (rise_sum < {1'b0, r_spd}) ? rise_sum[22:0] : r_spd;
        if (spd_lim < r_mins) begin
            spd_lim = r_mins;
        end
    end

    always_comb begin
        theta_raw = (r_zero ? '0 : cor_zo)
                    - ({{(Zw-16){r_hd[15]}}, r_hd} <<< 17);
        theta_w = theta_raw;
        if (theta_raw > PiQ30) begin
            theta_w = theta_raw - TwoPi;
        end else if (theta_raw < -PiQ30) begin
            theta_w = theta_raw + TwoPi;
        end
    end

    assign rot_x = signed'({{(Cw-39){1'b0}}, r_prod[52:14]});

    // cordic start values
    always_comb begin
        cor_ctl.start = 1'b0;
        cor_ctl.vec   = 1'b0;
        cor_x0 = '0;
        cor_y0 = '0;
        cor_z0 = '0;
        if (r_state == S_LIM) begin
            cor_ctl.start = 1'b1;
            cor_ctl.vec   = 1'b1;
            cor_x0 = {{(Cw-25){r_dx[24]}}, r_dx} <<< 8;
            cor_y0 = {{(Cw-25){r_dy[24]}}, r_dy} <<< 8;
            if (r_dx[24]) begin
                cor_z0 = r_dy[24] ? -PiQ30 : PiQ30;
                cor_x0 = -cor_x0;
                cor_y0 = -cor_y0;
            end
        end else if (r_state == S_ROT) begin
            cor_ctl.start = 1'b1;
            cor_x0 = rot_x;
            cor_z0 = r_theta;
            if (r_theta > HalfPi) begin
                cor_z0 = r_theta - PiQ30;
                cor_x0 = -rot_x;
            end else if (r_theta < -HalfPi) begin
                cor_z0 = r_theta + PiQ30;
                cor_x0 = -rot_x;
            end
        end
    end

    pvp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cor_ctl),
        .i_x     (cor_x0),
        .i_y     (cor_y0),
        .i_z     (cor_z0),
        .o_done  (cor_done),
        .o_x     (cor_xo),
        .o_y     (cor_yo),
        .o_z     (cor_zo)
    );

    assign rnd_x = (cor_xo + Cw'(32768)) >>> 16;
    assign rnd_y = (cor_yo + Cw'(32768)) >>> 16;

    function automatic logic signed [23:0] sat24(input logic signed [Cw-1:0] v);
        logic signed [23:0] s;
        if (v > Cw'(8388607)) begin
            s = 24'sd8388607;
        end else if (v < -Cw'(8388608)) begin
            s = -24'sd8388608;
        end else begin
            s = v[23:0];
        end
        return s;
    endfunction

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= 16'd512;
            r_maxs <= 23'd19661;
            r_acc  <= 23'd9830;
            r_mins <= 23'd6554;
            r_tol  <= 23'd328;
            r_tick <= 16'd1311;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_KP:   r_kp   <= i_cfg_data[15:0];
                REG_MAX_SPEED: r_maxs <= i_cfg_data;
                REG_ACCEL:     r_acc  <= i_cfg_data;
                REG_MIN_SPEED: r_mins <= i_cfg_data;
                REG_STOP_TOL:  r_tol  <= i_cfg_data;
                REG_TICK:      r_tick <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gx     <= '0;
            r_gy     <= '0;
            r_moving <= 1'b0;
            r_seen   <= 1'b0;
            r_lspd   <= '0;
            r_lvx    <= '0;
            r_lvy    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && !i_stall && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            r_prod <= 56'(mul_a * mul_b);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_kind == KIND_GOAL || i_kind == KIND_ABORT) begin
                            r_lspd <= '0;
                            r_lvx  <= '0;
                            r_lvy  <= '0;
                            if (i_kind == KIND_ABORT ||
                                (i_pos_x == AbortPos && i_pos_y == AbortPos)) begin
                                r_moving <= 1'b0;
                            end else begin
                                r_gx     <= i_pos_x;
                                r_gy     <= i_pos_y;
                                r_moving <= 1'b1;
                                r_seen   <= 1'b1;
                            end
                        end else if (i_kind == KIND_TICK && r_seen) begin
                            if (!r_moving) begin
                                r_rx    <= r_lvx;
                                r_ry    <= r_lvy;
                                r_rr    <= 1'b0;
                                r_state <= S_OUT;
                            end else begin
                                r_dx    <= 25'(r_gx) - 25'(i_pos_x);
                                r_dy    <= 25'(r_gy) - 25'(i_pos_y);
                                r_hd    <= i_heading;
                                r_state <= S_SQA;
                            end
                        end
                    end
                end
                S_SQA: begin
                    r_zero  <= (r_dx == '0) && (r_dy == '0);
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_n     <= r_prod[51:0];
                    r_state <= S_SQC;
                end
                S_SQC: begin
                    r_n     <= r_n + r_prod[51:0];
                    r_r     <= '0;
                    r_b     <= 52'd1 << 50;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_n >= r_r + r_b) begin
                        r_n <= sq_t;
                        r_r <= (r_r >> 1) + r_b;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_b   <= r_b >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SqrtLast) begin
                        r_state <= S_KP;
                    end
                end
                S_KP: begin
                    if (r_r < {29'b0, r_tol}) begin
                        r_lspd  <= '0;
                        r_lvx   <= '0;
                        r_lvy   <= '0;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_rr    <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_spd   <= (r_prod[41:8] > {11'b0, r_maxs}) ? r_maxs : r_prod[30:8];
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_spd   <= spd_lim;
                    r_state <= S_VEC;
                end
                S_VEC: begin
                    if (cor_done) begin
                        r_theta <= theta_w;
                        r_state <= S_INV;
                    end
                end
                S_INV: begin
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_state <= S_RWT;
                end
                S_RWT: begin
                    if (cor_done) begin
                        r_lspd  <= r_spd;
                        r_lvx   <= sat24(rnd_x);
                        r_lvy   <= sat24(rnd_y);
                        r_rx    <= sat24(rnd_x);
                        r_ry    <= sat24(rnd_y);
                        r_rr    <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov    <= 1'b1;
                        r_ovx   <= r_rx;
                        r_ovy   <= r_ry;
                        r_ovr   <= r_rr;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_ov;
    assign o_vel_x   = r_ovx;
    assign o_vel_y   = r_ovy;
    assign o_reached = r_ovr;

    a_reached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reached |-> o_vel_x == 24'sd0 && o_vel_y == 24'sd0)
        else $error("reached result with nonzero velocity");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> (r_state == S_VEC || r_state == S_RWT))
        else $error("cordic finished outside a wait state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && r_ov && i_stall |=> r_state == S_OUT && r_ov)
        else $error("result sequencer left while output stalled");

endmodule

// ===== verif/tb_point_to_point_velocity_profiler.sv =====
`timescale 1ns / 1ps
module tb_point_to_point_velocity_profiler;
    import pvp_pkg::*;

    localparam longint PiQ30 = 64'sd3373259426;
    localparam longint HalfPiQ30 = 64'sd1686629713;
    localparam longint TwoPiQ30 = 64'sd6746518852;
    localparam longint InvKQ30 = 64'sd652032874;
    localparam longint AbortCoord = -64'sd65536;
    localparam int Steps = 16;
    localparam int IdleLimit = 20000;
    localparam int SettleCycles = 120;
    localparam int RandomPerPhase = 165;

    typedef struct {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic               reached;
    } t_velocity;

    typedef struct {
        logic [1:0]         kind;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [15:0] hd;
        bit                 typed;
        t_velocity          vel;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_kind = KIND_GOAL;
    logic signed [23:0] i_pos_x = '0;
    logic signed [23:0] i_pos_y = '0;
    logic signed [15:0] i_heading = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [23:0] o_vel_x;
    logic signed [23:0] o_vel_y;
    logic               o_reached;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = REG_GAIN_KP;
    logic [22:0]        i_cfg_data = '0;

    point_to_point_velocity_profiler uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and configuration copy
    longint unsigned kp_q, vmax_q, accel_q, vmin_q, tol_q, period_q;
    longint          goal_x, goal_y, prev_vx, prev_vy;
    longint unsigned prev_speed;
    bit              in_motion, have_goal;

    t_velocity expected_vel[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        hold_request = 1'b0;
    bit        row_typed = 1'b0;
    t_velocity row_vel;
    longint    atan_tab[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint bearing_to(longint dx, longint dy);
        longint x, y, z, nx;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (dx < 0) begin
            z = (dy >= 0) ? PiQ30 : -PiQ30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < Steps; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // returns 1 when the item produces a velocity command
    function automatic bit plan_velocity(logic [1:0] kind, longint px, longint py,
                                         longint hd, output t_velocity vel);
        longint          dx, dy, theta, x, y, z, nx;
        longint unsigned dist_q, spd, rise;
        vel = '{vx: '0, vy: '0, reached: 1'b0};
        if (kind == KIND_GOAL || kind == KIND_ABORT) begin
            prev_speed = 0;
            prev_vx = 0;
            prev_vy = 0;
            if (kind == KIND_ABORT || (px == AbortCoord && py == AbortCoord)) begin
                in_motion = 1'b0;
                return 1'b0;
            end
            goal_x = px;
            goal_y = py;
            in_motion = 1'b1;
            have_goal = 1'b1;
            return 1'b0;
        end
        if (kind != KIND_TICK || !have_goal) return 1'b0;
        if (!in_motion) begin
            vel.vx = prev_vx[23:0];
            vel.vy = prev_vy[23:0];
            return 1'b1;
        end
        dx = goal_x - px;
        dy = goal_y - py;
        dist_q = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
        if (dist_q < tol_q) begin
            prev_speed = 0;
            prev_vx = 0;
            prev_vy = 0;
            vel.reached = 1'b1;
            return 1'b1;
        end
        spd = (dist_q * kp_q) >> 8;
        if (spd > vmax_q) spd = vmax_q;
        rise = (accel_q * period_q) >> 16;
        if (prev_speed + rise < spd) spd = prev_speed + rise;
        if (spd < vmin_q) spd = vmin_q;
        theta = bearing_to(dx, dy) - hd * 131072;
        if (theta > PiQ30) theta = theta - TwoPiQ30;
        else if (theta < -PiQ30) theta = theta + TwoPiQ30;
        x = longint'((spd * longint'(InvKQ30)) >> 14);
        y = 0;
        if (theta > HalfPiQ30) begin
            theta = theta - PiQ30;
            x = -x;
        end else if (theta < -HalfPiQ30) begin
            theta = theta + PiQ30;
            x = -x;
        end
        z = theta;
        for (int i = 0; i < Steps; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            x = nx;
        end
        prev_speed = spd;
        prev_vx = clip24((x + 32768) >>> 16);
        prev_vy = clip24((y + 32768) >>> 16);
        vel.vx = prev_vx[23:0];
        vel.vy = prev_vy[23:0];
        return 1'b1;
    endfunction

    // accepted transfers: predict on input, compare on output
    always @(posedge i_clk) begin
        t_velocity pv, ev;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_vel.size() == 0) begin
                    $display("%0t: unexpected result vx=%0d vy=%0d reached=%0d",
                             $time, o_vel_x, o_vel_y, o_reached);
                    errors++;
                end else begin
                    ev = expected_vel.pop_front();
                    if (o_vel_x !== ev.vx) begin
                        $display("%0t: vel_x expected %0d actual %0d", $time, ev.vx, o_vel_x);
                        errors++;
                    end
                    if (o_vel_y !== ev.vy) begin
                        $display("%0t: vel_y expected %0d actual %0d", $time, ev.vy, o_vel_y);
                        errors++;
                    end
                    if (o_reached !== ev.reached) begin
                        $display("%0t: reached expected %0d actual %0d",
                                 $time, ev.reached, o_reached);
                        errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                if (plan_velocity(i_kind, i_pos_x, i_pos_y, i_heading, pv))
                    expected_vel.push_back(row_typed ? row_vel : pv);
            end
            if (idle_cycles >= IdleLimit) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stall per result, one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                n = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 16);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    int  sender_gap_mode = 0;
    bit  sender_up = 1'b0;

    task automatic send_item(logic [1:0] kind, logic signed [23:0] px,
                             logic signed [23:0] py, logic signed [15:0] hd);
        int gap;
        gap = (sender_gap_mode == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0 && sender_up) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_pos_x <= px;
        i_pos_y <= py;
        i_heading <= hd;
        sender_up = 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_and_settle();
        if (sender_up) i_valid <= 1'b0;
        sender_up = 1'b0;
        while (expected_vel.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] kp, logic [22:0] vmax, logic [22:0] acc,
                              logic [22:0] vmin, logic [22:0] tol, logic [15:0] per);
        logic [22:0] vals[6];
        logic [2:0]  idx[6];
        vals = '{23'(kp), vmax, acc, vmin, tol, 23'(per)};
        idx = '{REG_GAIN_KP, REG_MAX_SPEED, REG_ACCEL, REG_MIN_SPEED, REG_STOP_TOL, REG_TICK};
        drain_and_settle();
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        kp_q = kp;
        vmax_q = vmax;
        accel_q = acc;
        vmin_q = vmin;
        tol_q = tol;
        period_q = per;
    endtask

    function automatic logic signed [15:0] rand_heading();
        return 16'(int'($urandom_range(0, 51472)) - 25736);
    endfunction

    task automatic random_item(bit near_mode);
        int                 pick;
        logic signed [23:0] px, py;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            if ($urandom_range(0, 1) == 1)
                send_item(KIND_GOAL, 24'($urandom), 24'($urandom), 16'($urandom));
            else
                send_item(KIND_GOAL, 24'(int'($urandom_range(0, 4000000)) - 2000000),
                          24'(int'($urandom_range(0, 4000000)) - 2000000), 16'($urandom));
        end else if (pick < 14) begin
            send_item(KIND_ABORT, 24'($urandom), 24'($urandom), 16'($urandom));
        end else if (pick < 17) begin
            send_item(KIND_GOAL, 24'(AbortCoord), 24'(AbortCoord), 16'($urandom));
        end else if (pick < 19) begin
            send_item(2'd3, 24'($urandom), 24'($urandom), 16'($urandom));
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 1 || (near_mode && pick < 3)) begin
                px = goal_x[23:0];
                py = goal_y[23:0];
            end else if (pick < 6) begin
                px = goal_x[23:0] + 24'(int'($urandom_range(0, 8192)) - 4096);
                py = goal_y[23:0] + 24'(int'($urandom_range(0, 8192)) - 4096);
            end else begin
                px = 24'($urandom);
                py = 24'($urandom);
            end
            send_item(KIND_TICK, px, py, rand_heading());
        end
    endtask

    t_row directed[] = '{
        '{KIND_TICK, 24'sd1000, 24'sd1000, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_GOAL, 24'sd0, 24'sd0, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd0, 24'sd0, 16'sd0, 1'b1, '{0, 0, 1}},
        '{KIND_TICK, 24'sd100000, 24'sd0, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd0, -24'sd200000, 16'sd25736, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, -24'sd300000, 24'sd50000, -16'sd25736, 1'b0, '{0, 0, 0}},
        '{KIND_GOAL, 24'sd8388607, -24'sd8388608, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, -24'sd8388608, 24'sd8388607, 16'sd25736, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd8388607, 24'sd8388607, -16'sd25736, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, -24'sd8388608, -24'sd8388608, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd8388607, -24'sd8388608, 16'sd0, 1'b1, '{0, 0, 1}},
        '{KIND_TICK, 24'sd8388000, -24'sd8388608, 16'sd12868, 1'b0, '{0, 0, 0}},
        '{KIND_GOAL, -24'sd65536, -24'sd65536, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd0, 24'sd0, 16'sd0, 1'b1, '{0, 0, 0}},
        '{KIND_GOAL, -24'sd1000000, 24'sd1000000, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd0, 24'sd0, 16'sd100, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd5000, 24'sd0, -16'sd100, 1'b0, '{0, 0, 0}},
        '{KIND_ABORT, 24'sd0, 24'sd0, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd1, 24'sd1, 16'sd1, 1'b1, '{0, 0, 0}},
        '{2'd3, 24'sd777, 24'sd777, 16'sd7, 1'b0, '{0, 0, 0}},
        '{KIND_GOAL, 24'sd50000, 24'sd50000, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_TICK, 24'sd50000, 24'sd50000, 16'sd0, 1'b1, '{0, 0, 1}},
        '{KIND_TICK, 24'sd0, 24'sd60000, 16'sd0, 1'b0, '{0, 0, 0}},
        '{KIND_GOAL, 24'sd0, -24'sd65536, 16'sd0, 1'b0, '{0, 0, 0}}
    };

    initial begin
        t_row row;
        kp_q = 512;
        vmax_q = 19661;
        accel_q = 9830;
        vmin_q = 6554;
        tol_q = 328;
        period_q = 1311;
        goal_x = 0;
        goal_y = 0;
        prev_vx = 0;
        prev_vy = 0;
        prev_speed = 0;
        in_motion = 1'b0;
        have_goal = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; typed values override the prediction
        foreach (directed[k]) begin
            row = directed[k];
            sender_gap_mode = k % 2;
            row_typed <= row.typed;
            row_vel <= row.vel;
            send_item(row.kind, row.px, row.py, row.hd);
        end
        row_typed <= 1'b0;

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_regs(16'd512, 23'd19661, 23'd9830, 23'd6554, 23'd328, 16'd1311);
                1: write_regs(16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF,
                              16'hFFFF);
                2: write_regs(16'd0, 23'd0, 23'd0, 23'd0, 23'd0, 16'd0);
                3: write_regs(16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'd0, 23'd0, 16'hFFFF);
                4: write_regs(16'd1, 23'd100000, 23'd500000, 23'd1000, 23'd5000, 16'd1);
                default: write_regs(16'($urandom), 23'($urandom), 23'($urandom),
                                    23'($urandom_range(0, 30000)),
                                    23'($urandom_range(0, 20000)), 16'($urandom));
            endcase
            for (int n = 0; n < RandomPerPhase; n++) begin
                sender_gap_mode = ((n / 40) % 3 == 1) ? 0 : 1;
                // receiver holds off while the sender keeps offering
                if (phase == 1 && n == 20) begin
                    hold_request = 1'b1;
                    sender_gap_mode = 0;
                end
                random_item(phase == 2 || phase == 3);
            end
        end

        drain_and_settle();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
